/* hw/rtl/dtt_pkg.sv */
package dtt_pkg;

  localparam int NUM_SLOTS_DEF = 16;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  localparam logic [30:0] WAIT_MAX = 31'h7FFF_FFFF;

  // request selector carried in s_axis_tuser
  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_KILL  = 2'd1,
    ACT_CHECK = 2'd2
  } act_e;

  // result kind carried in m_axis_tuser
  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_KILL  = 2'd1,
    KIND_FIRED = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  // what to do with the smallest queued key found by a scan
  typedef enum logic [1:0] {
    DEC_FINISH = 2'd0,
    DEC_REKEY  = 2'd1,
    DEC_FIRE   = 2'd2,
    DEC_DROP   = 2'd3
  } dec_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_EXEC   = 3'd1,
    ST_SCAN   = 3'd2,
    ST_DRAIN  = 3'd3,
    ST_DECIDE = 3'd4
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic exec_sk;
    logic scan_init;
    logic scan_step;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    dec_e       dec;
    logic       out_free;
    logic       scan_last;
  } sts_t;

endpackage

/* hw/rtl/deadline_timer_table_unit.sv */
// table of one-shot timers, ordered by queue key
//
// s_axis: one request per beat. set arms a slot with deadline now+delay (delay 0
//   cancels), kill marks a queued slot to be dropped silently, check handles all
//   due keys in ascending order, ties to the lower slot.
// m_axis: one beat per result. set and kill give a single beat; check gives one
//   fired beat per expired slot, then a finishing beat with the wait to the next
//   queued key (0 if none), which carries tlast.
// flow: a set or kill result is registered from the exec state, which holds until
//   the output register is free. every step of a check is a full pass over the
//   key store, one slot a cycle through its single read port, then a drain and a
//   decision state; the decision waits for a free output register when it gives
//   a beat. a check takes one step per due entry handled (fired, dropped or
//   re-keyed) and one more that finds nothing due and gives the finishing beat.
//   a new request is taken only once the block is back in idle.
// stall: results sit in an output register; the next request is still taken
//   while a result waits, and the block then holds until the register frees.
// reset: all slots idle, no kill pending; the deadline and key stores need no
//   clearing since a slot's values are only used once a set has queued it.
module deadline_timer_table_unit #(
  parameter int NUM_SLOTS = dtt_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: timer_id[3:0], delay[27:4], now_time[58:28], zero fill
  input  logic [dtt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]                     s_axis_tuser,
  // result channel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: slot[3:0], was_idle[4], next_wait[35:5], zero fill
  output logic [dtt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: kind[1:0]
  output logic [1:0]                     m_axis_tuser,
  output logic                           m_axis_tlast
);

  dtt_pkg::cmd_t cmd;
  dtt_pkg::sts_t sts;

  // sequencing of request, scan passes and decisions
  dtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot stores, minimum search and result register
  dtt_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_user_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

/* hw/rtl/dtt_ctrl.sv */
module dtt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dtt_pkg::sts_t sts_i,
  output dtt_pkg::cmd_t cmd_o
);

  dtt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    logic need_out;
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    need_out   = (sts_i.dec == dtt_pkg::DEC_FINISH) || (sts_i.dec == dtt_pkg::DEC_FIRE);
    unique case (state_q)
      dtt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = dtt_pkg::ST_EXEC;
        end
      end
      dtt_pkg::ST_EXEC: begin
        case (sts_i.act)
          dtt_pkg::ACT_SET, dtt_pkg::ACT_KILL: begin
            if (sts_i.out_free) begin
              cmd_o.exec_sk = 1'b1;
              state_d       = dtt_pkg::ST_IDLE;
            end
          end
          dtt_pkg::ACT_CHECK: begin
            cmd_o.scan_init = 1'b1;
            state_d         = dtt_pkg::ST_SCAN;
          end
          default: begin
            state_d = dtt_pkg::ST_IDLE;
          end
        endcase
      end
      dtt_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = dtt_pkg::ST_DRAIN;
        end
      end
      dtt_pkg::ST_DRAIN: begin
        state_d = dtt_pkg::ST_DECIDE;
      end
      dtt_pkg::ST_DECIDE: begin
        if (!need_out || sts_i.out_free) begin
          cmd_o.decide = 1'b1;
          if (sts_i.dec == dtt_pkg::DEC_FINISH) begin
            state_d = dtt_pkg::ST_IDLE;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = dtt_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_d = dtt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/dtt_datapath.sv */
module dtt_datapath #(
  parameter int NUM_SLOTS = dtt_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dtt_pkg::cmd_t                  cmd_i,
  output dtt_pkg::sts_t                  sts_o,
  input  logic [1:0]                     in_user_i,
  input  logic [dtt_pkg::IN_DATA_W-1:0]  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     out_user_o,
  output logic [dtt_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic                           out_last_o
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // latched request
  logic [1:0]  act_q;
  logic [3:0]  id_q;
  logic [23:0] delay_q;
  logic [30:0] now_q;

  // per-slot flags
  logic [NUM_SLOTS-1:0] queued_q, queued_d;
  logic [NUM_SLOTS-1:0] kp_q, kp_d;

  // deadline and queue key stores
  logic [31:0] dl_mem  [NUM_SLOTS];
  logic [31:0] key_mem [NUM_SLOTS];

  // scan pipeline
  logic [IDX_W-1:0] cnt_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [31:0]      rd_key_q;
  logic [31:0]      rd_dl_q;

  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [31:0]      best_key_q;
  logic [31:0]      best_dl_q;

  // output register
  logic            out_valid_q;
  dtt_pkg::kind_e  out_kind_q;
  logic [3:0]      out_slot_q;
  logic            out_idle_q;
  logic [30:0]     out_wait_q;
  logic            out_last_q;

  logic             id_ok;
  logic [IDX_W-1:0] id_idx;
  logic             id_queued;
  logic [31:0]      now_w;
  logic [31:0]      new_dl;
  logic [31:0]      diff;
  dtt_pkg::dec_e    dec;
  logic [30:0]      wait_v;
  logic             is_set, is_kill;
  logic             emit;
  logic             out_free;
  logic             key_we;
  logic [IDX_W-1:0] key_wa;
  logic [31:0]      key_wd;
  logic             take;

  assign id_ok     = 32'(id_q) < NUM_SLOTS;
  assign id_idx    = IDX_W'(id_q);
  assign id_queued = id_ok && queued_q[id_idx];
  assign now_w     = 32'(now_q);
  assign new_dl    = (delay_q == 24'd0) ? 32'd0 : now_w + 32'(delay_q);
  assign diff      = best_key_q - now_w;
  assign is_set    = (act_q == dtt_pkg::ACT_SET);
  assign is_kill   = (act_q == dtt_pkg::ACT_KILL);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    dec    = dtt_pkg::DEC_FINISH;
    wait_v = '0;
    priority if (!found_q) begin
      dec = dtt_pkg::DEC_FINISH;
    end else if (best_key_q > now_w) begin
      dec    = dtt_pkg::DEC_FINISH;
      wait_v = diff[31] ? dtt_pkg::WAIT_MAX : diff[30:0];
    end else if (best_dl_q > now_w) begin
      dec = dtt_pkg::DEC_REKEY;
    end else if (kp_q[best_idx_q] || (best_dl_q == 32'd0)) begin
      dec = dtt_pkg::DEC_DROP;
    end else begin
      dec = dtt_pkg::DEC_FIRE;
    end
  end

  assign emit = cmd_i.exec_sk ||
                (cmd_i.decide && ((dec == dtt_pkg::DEC_FINISH) || (dec == dtt_pkg::DEC_FIRE)));

  assign sts_o.act       = act_q;
  assign sts_o.dec       = dec;
  assign sts_o.out_free  = out_free;
  assign sts_o.scan_last = (cnt_q == IDX_W'(NUM_SLOTS - 1));

  // flag updates
  always_comb begin
    queued_d = queued_q;
    kp_d     = kp_q;
    if (cmd_i.exec_sk && is_set && id_ok) begin
      queued_d[id_idx] = 1'b1;
    end
    if (cmd_i.exec_sk && is_kill && id_queued) begin
      kp_d[id_idx] = 1'b1;
    end
    if (cmd_i.decide && ((dec == dtt_pkg::DEC_FIRE) || (dec == dtt_pkg::DEC_DROP))) begin
      queued_d[best_idx_q] = 1'b0;
      kp_d[best_idx_q]     = 1'b0;
    end
  end

  // key store write port: new entry on set, re-key on a stale due key
  always_comb begin
    key_we = 1'b0;
    key_wa = id_idx;
    key_wd = new_dl;
    if (cmd_i.exec_sk && is_set && id_ok && !queued_q[id_idx]) begin
      key_we = 1'b1;
    end else if (cmd_i.decide && (dec == dtt_pkg::DEC_REKEY)) begin
      key_we = 1'b1;
      key_wa = best_idx_q;
      key_wd = best_dl_q;
    end
  end

  assign take = rd_vld_q && queued_q[rd_idx_q] && (!found_q || (rd_key_q < best_key_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      act_q   <= in_user_i;
      id_q    <= in_data_i[3:0];
      delay_q <= in_data_i[27:4];
      now_q   <= in_data_i[58:28];
    end
    if (cmd_i.exec_sk && is_set && id_ok) begin
      dl_mem[id_idx] <= new_dl;
    end
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (cmd_i.scan_step) begin
      rd_key_q <= key_mem[cnt_q];
      rd_dl_q  <= dl_mem[cnt_q];
      rd_idx_q <= cnt_q;
    end
    if (take) begin
      best_idx_q <= rd_idx_q;
      best_key_q <= rd_key_q;
      best_dl_q  <= rd_dl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q    <= '0;
      kp_q        <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      queued_q <= queued_d;
      kp_q     <= kp_d;
      rd_vld_q <= cmd_i.scan_step;
      if (cmd_i.scan_init) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          cnt_q <= cnt_q + IDX_W'(1);
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (cmd_i.exec_sk) begin
        out_kind_q <= is_set ? dtt_pkg::KIND_SET : dtt_pkg::KIND_KILL;
        out_slot_q <= id_q;
        out_idle_q <= is_kill && !id_queued;
        out_wait_q <= '0;
        out_last_q <= 1'b1;
      end else if (dec == dtt_pkg::DEC_FIRE) begin
        out_kind_q <= dtt_pkg::KIND_FIRED;
        out_slot_q <= 4'(best_idx_q);
        out_idle_q <= 1'b0;
        out_wait_q <= '0;
        out_last_q <= 1'b0;
      end else begin
        out_kind_q <= dtt_pkg::KIND_DONE;
        out_slot_q <= '0;
        out_idle_q <= 1'b0;
        out_wait_q <= wait_v;
        out_last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_kind_q;
  assign out_data_o  = {4'b0, out_wait_q, out_idle_q, out_slot_q};
  assign out_last_o  = out_last_q;

  a_kill_needs_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kp_q & ~queued_q) == '0)
    else $error("kill pending on a slot that is not queued");

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result loaded over a beat not yet taken");

  a_last_by_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_last_q == (out_kind_q != dtt_pkg::KIND_FIRED)))
    else $error("last flag does not match result kind");

  a_scan_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_init |=> (cnt_q == '0) && !found_q)
    else $error("scan did not restart from the first slot");

endmodule

/* test/tb_deadline_timer_table_unit.sv */
module tb_deadline_timer_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_SLOTS   = dtt_pkg::NUM_SLOTS_DEF;
  // no enum member exists for the spare selector code
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  // cycles without any beat on either side before the run is abandoned
  localparam int          QUIET_LIMIT = 5000;
  // length of the deliberate hold on the result side
  localparam int          HOLD_CYCLES = 400;
  localparam logic [23:0] DELAY_MAX   = 24'hFF_FFFF;

  typedef struct {
    dtt_pkg::kind_e kind;
    logic [3:0]     slot;
    logic           was_idle;
    logic [30:0]    next_wait;
    logic           last;
  } result_beat_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [dtt_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]                     s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [dtt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]                     m_axis_tuser;
  logic                           m_axis_tlast;

  // shadow copy of the timer table
  logic [31:0] timer_deadline [NUM_SLOTS];
  logic [31:0] timer_key      [NUM_SLOTS];
  logic        timer_queued   [NUM_SLOTS];
  logic        timer_killed   [NUM_SLOTS];

  // result beats still owed by the block, oldest first
  result_beat_t awaited_beats[$];
  result_beat_t head_beat;

  logic [30:0] time_base;
  logic        request_gaps_on;
  logic        result_stalls_on;
  logic        hold_results_request;
  int          error_count;
  int          quiet_cycles;
  int          results_seen;
  int          fired_seen;
  int          request_count [4];

  deadline_timer_table_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // works out the result beats of one accepted request and updates the shadow table
  function automatic void predict_timer_results(logic [1:0] act, logic [3:0] id,
                                                logic [23:0] delay, logic [30:0] now);
    logic [31:0] t_now;
    logic [31:0] gap;
    logic [30:0] wait_ticks;
    logic        idle;
    int          best;
    t_now      = {1'b0, now};
    wait_ticks = '0;
    case (act)
      dtt_pkg::ACT_SET: begin
        timer_deadline[id] = (delay == '0) ? 32'd0 : t_now + {8'd0, delay};
        // a slot already queued keeps its old key
        if (!timer_queued[id]) begin
          timer_queued[id] = 1'b1;
          timer_key[id]    = timer_deadline[id];
        end
        awaited_beats.push_back('{dtt_pkg::KIND_SET, id, 1'b0, 31'd0, 1'b1});
      end
      dtt_pkg::ACT_KILL: begin
        idle = !timer_queued[id];
        if (timer_queued[id]) timer_killed[id] = 1'b1;
        awaited_beats.push_back('{dtt_pkg::KIND_KILL, id, idle, 31'd0, 1'b1});
      end
      dtt_pkg::ACT_CHECK: begin
        forever begin
          // smallest key, ties to the lower slot
          best = -1;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (timer_queued[i] && (best < 0 || timer_key[i] < timer_key[best])) best = i;
          end
          if (best < 0) break;
          if (timer_key[best] > t_now) begin
            gap        = timer_key[best] - t_now;
            wait_ticks = (gap > {1'b0, dtt_pkg::WAIT_MAX}) ? dtt_pkg::WAIT_MAX : gap[30:0];
            break;
          end
          if (timer_deadline[best] > t_now) begin
            // re-armed later than its key: re-key, not due again in this check
            timer_key[best] = timer_deadline[best];
          end else begin
            timer_queued[best] = 1'b0;
            if (timer_killed[best]) begin
              timer_killed[best]   = 1'b0;
              timer_deadline[best] = '0;
            end else if (timer_deadline[best] != '0) begin
              timer_deadline[best] = '0;
              awaited_beats.push_back('{dtt_pkg::KIND_FIRED, 4'(best), 1'b0, 31'd0, 1'b0});
            end
          end
        end
        awaited_beats.push_back('{dtt_pkg::KIND_DONE, 4'd0, 1'b0, wait_ticks, 1'b1});
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [30:0] got,
                                 input logic [30:0] want);
    error_count++;
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, field, got, want);
  endtask

  // offers one request beat, waits for it to be taken, then maybe leaves a gap
  task automatic send_request(input logic [1:0] act, input logic [3:0] id,
                              input logic [23:0] delay, input logic [30:0] now);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {5'd0, now, delay, id};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predict_timer_results(act, id, delay, now);
    request_count[act]++;
    if (request_gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // each operation and the corner cases of the table, hand-placed
  task automatic test_directed_cases();
    send_request(dtt_pkg::ACT_CHECK, 4'd0, 24'd0, 31'd0);     // empty table
    send_request(dtt_pkg::ACT_KILL, 4'd0, 24'd0, 31'd0);      // kill on an idle slot
    send_request(dtt_pkg::ACT_SET, 4'd0, 24'd10, 31'd100);
    send_request(dtt_pkg::ACT_SET, 4'd15, 24'd10, 31'd100);   // same key as slot 0
    send_request(dtt_pkg::ACT_SET, 4'd3, 24'd0, 31'd100);     // cancel on an unqueued slot
    send_request(dtt_pkg::ACT_CHECK, 4'd0, 24'd0, 31'd105);   // cancelled slot leaves silently
    send_request(dtt_pkg::ACT_CHECK, 4'd0, 24'd0, 31'd110);   // tie goes to the lower slot
    send_request(dtt_pkg::ACT_SET, 4'd5, 24'd20, 31'd200);
    send_request(dtt_pkg::ACT_SET, 4'd5, 24'd50, 31'd210);    // re-arm keeps the old key
    send_request(dtt_pkg::ACT_CHECK, 4'd0, 24'd0, 31'd230);   // re-key only
    send_request(dtt_pkg::ACT_CHECK, 4'd0, 24'd0, 31'd260);
    send_request(dtt_pkg::ACT_SET, 4'd7, 24'd5, 31'd300);
    send_request(dtt_pkg::ACT_KILL, 4'd7, 24'd0, 31'd300);    // kill deferred
    send_request(dtt_pkg::ACT_SET, 4'd7, 24'd8, 31'd301);     // kill survives a set
    send_request(dtt_pkg::ACT_CHECK, 4'd0, 24'd0, 31'd400);   // killed slot dropped silently
    send_request(dtt_pkg::ACT_KILL, 4'd7, 24'd0, 31'd400);
    send_request(dtt_pkg::ACT_SET, 4'd9, 24'd30, 31'd400);
    send_request(dtt_pkg::ACT_SET, 4'd9, 24'd0, 31'd401);     // cancel on a queued slot
    send_request(dtt_pkg::ACT_CHECK, 4'd0, 24'd0, 31'd430);
    send_request(ACT_UNUSED, 4'hF, DELAY_MAX, dtt_pkg::WAIT_MAX); // spare selector, no result
    send_request(dtt_pkg::ACT_KILL, 4'hF, DELAY_MAX, dtt_pkg::WAIT_MAX);
  endtask

  // every slot due at once: the longest burst of fired beats
  task automatic test_all_slots_fire();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_request(dtt_pkg::ACT_SET, 4'(i), 24'($urandom_range(1, 50)), 31'd1000);
    end
    send_request(dtt_pkg::ACT_CHECK, 4'd0, 24'd0, 31'd2000);
    time_base = 31'd3000;
  endtask

  // mostly sets and checks on an advancing clock, with kills, far jumps and noise
  task automatic test_random_traffic(input int n_items);
    int          roll;
    int          pick;
    logic [23:0] dly;
    logic [3:0]  id;
    for (int k = 0; k < n_items; k++) begin
      roll      = $urandom_range(0, 99);
      id        = 4'($urandom_range(0, 15));
      time_base = time_base + 31'($urandom_range(0, 60));
      if (roll < 45) begin
        pick = $urandom_range(0, 19);
        dly  = (pick == 0) ? 24'd0 : (pick == 1) ? 24'($urandom) : 24'($urandom_range(1, 300));
        send_request(dtt_pkg::ACT_SET, id, dly, time_base);
      end else if (roll < 60) begin
        send_request(dtt_pkg::ACT_KILL, id, 24'($urandom), 31'($urandom));
      end else if (roll < 92) begin
        send_request(dtt_pkg::ACT_CHECK, id, 24'($urandom), time_base);
      end else if (roll < 96) begin
        // jump past every far deadline so the table empties
        time_base = time_base + (31'd1 << 25);
        send_request(dtt_pkg::ACT_CHECK, id, 24'($urandom), time_base);
      end else begin
        send_request(ACT_UNUSED, id, 24'($urandom), 31'($urandom));
      end
    end
  endtask

  // the result side holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    logic gaps_were_on;
    gaps_were_on         = request_gaps_on;
    request_gaps_on      = 1'b0;
    hold_results_request = 1'b1;
    for (int k = 0; k < 20; k++) begin
      time_base = time_base + 31'($urandom_range(0, 40));
      if ($urandom_range(0, 2) == 0)
        send_request(dtt_pkg::ACT_CHECK, 4'd0, 24'd0, time_base);
      else
        send_request(dtt_pkg::ACT_SET, 4'($urandom_range(0, 15)),
                     24'($urandom_range(1, 100)), time_base);
    end
    request_gaps_on = gaps_were_on;
  endtask

  // keys beyond the 31-bit wait range: saturation of the wait
  task automatic test_wide_wait();
    send_request(dtt_pkg::ACT_CHECK, 4'd0, 24'd0, dtt_pkg::WAIT_MAX);   // clears whatever is left
    send_request(dtt_pkg::ACT_SET, 4'd4, DELAY_MAX, dtt_pkg::WAIT_MAX);
    send_request(dtt_pkg::ACT_CHECK, 4'd0, 24'd0, 31'd0);
    send_request(dtt_pkg::ACT_CHECK, 4'd0, 24'd0, dtt_pkg::WAIT_MAX);
    send_request(dtt_pkg::ACT_KILL, 4'd4, 24'd0, 31'd0);
    send_request(dtt_pkg::ACT_SET, 4'd4, 24'd1, 31'd0);
    send_request(dtt_pkg::ACT_CHECK, 4'd0, 24'd0, 31'd5);
  endtask

  // result side: random stall bursts, plus the long hold when asked
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_results_request) begin
        hold_results_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (result_stalls_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checking against the oldest awaited beat, plus the watchdog
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser == dtt_pkg::KIND_FIRED) fired_seen++;
      if (awaited_beats.size() == 0) begin
        report_mismatch("beat with nothing awaited, kind", 31'(m_axis_tuser), 31'd0);
      end else begin
        head_beat = awaited_beats.pop_front();
        if (m_axis_tuser !== head_beat.kind)
          report_mismatch("kind", 31'(m_axis_tuser), 31'(head_beat.kind));
        if (m_axis_tdata[3:0] !== head_beat.slot)
          report_mismatch("slot", 31'(m_axis_tdata[3:0]), 31'(head_beat.slot));
        if (m_axis_tdata[4] !== head_beat.was_idle)
          report_mismatch("was_idle", 31'(m_axis_tdata[4]), 31'(head_beat.was_idle));
        if (m_axis_tdata[35:5] !== head_beat.next_wait)
          report_mismatch("next_wait", m_axis_tdata[35:5], head_beat.next_wait);
        if (m_axis_tlast !== head_beat.last)
          report_mismatch("last", 31'(m_axis_tlast), 31'(head_beat.last));
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results awaited",
               QUIET_LIMIT, awaited_beats.size());
      $display("tb_deadline_timer_table_unit: done, errors");
      $finish;
    end
  end

  initial begin
    s_axis_tvalid        = 1'b0;
    s_axis_tdata         = '0;
    s_axis_tuser         = '0;
    rst_ni               = 1'b0;
    request_gaps_on      = 1'b1;
    result_stalls_on     = 1'b1;
    hold_results_request = 1'b0;
    time_base            = '0;
    error_count          = 0;
    quiet_cycles         = 0;
    results_seen         = 0;
    fired_seen           = 0;
    for (int i = 0; i < 4; i++) request_count[i] = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      timer_deadline[i] = '0;
      timer_key[i]      = '0;
      timer_queued[i]   = 1'b0;
      timer_killed[i]   = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_all_slots_fire();
    test_random_traffic(275);
    test_backpressure();
    // closing stretch runs without any idling
    request_gaps_on  = 1'b0;
    result_stalls_on = 1'b0;
    test_random_traffic(40);
    test_wide_wait();
    s_axis_tvalid <= 1'b0;

    while (awaited_beats.size() != 0) @(posedge clk_i);
    // room for any stray beat to show up
    repeat (50) @(posedge clk_i);

    $display("requests: %0d set, %0d kill, %0d check, %0d spare selector",
             request_count[dtt_pkg::ACT_SET], request_count[dtt_pkg::ACT_KILL],
             request_count[dtt_pkg::ACT_CHECK], request_count[ACT_UNUSED]);
    $display("results: %0d beats checked, %0d timers fired, %0d mismatches",
             results_seen, fired_seen, error_count);
    if (error_count == 0) begin
      $display("tb_deadline_timer_table_unit: done, clean");
    end else begin
      $display("tb_deadline_timer_table_unit: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/dtt_pkg.sv
hw/rtl/dtt_ctrl.sv
hw/rtl/dtt_datapath.sv
hw/rtl/deadline_timer_table_unit.sv
test/tb_deadline_timer_table_unit.sv
